FILE: rtl/core/dwi_pkg.sv
// ----------------------------------------------------------------------------
// dwi_pkg
// Shared types and constants for the drowsiness window indicators.
// ----------------------------------------------------------------------------
package dwi_pkg;

  localparam int unsigned IvBits     = 10;
  localparam int unsigned HeightBits = 10;
  localparam int unsigned TimeBits   = 16;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BASELINE   = 3'd0,
    REG_PERCLOS_TH = 3'd1,
    REG_CLOSURE_TH = 3'd2,
    REG_PERCLOS_WIN = 3'd3,
    REG_BLINK_WIN  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]            eyes_found;
    logic [HeightBits-1:0] eye_height_a;
    logic [HeightBits-1:0] eye_height_b;
    logic [IvBits-1:0]     interval_ms;
  } dwi_in_t;

  typedef struct packed {
    logic [HeightBits:0]   eye_height;
    logic [12:0]           perclos_q12;
    logic [TimeBits-1:0]   closure_time_ms;
    logic [12:0]           microsleep_q12;
    logic [11:0]           blink_count;
  } dwi_out_t;

endpackage

FILE: rtl/core/drowsiness_window_indicators_top.sv
// ----------------------------------------------------------------------------
// drowsiness_window_indicators_top
// Eye height selection, PERCLOS and blink windows, closure timer, microsleep.
//
//  channel | direction | signals
//  in      | input     | in_valid_i, in_stall_o, in_data_i
//  out     | output    | out_valid_o, out_stall_i, out_data_o
//  cfg     | input     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// One frame at a time. After the request is taken the sequencer pops PERCLOS
// entries (one memory read each) while the span exceeds the window or the
// ring is full, pushes the new entry, starts the divider, does the same for
// the blink window, then scans the blink ring for runs. The divider runs
// beside the blink pops and scan. Reset clears the FSM, ring heads, counts,
// spans, timer and last height; rings need no clearing. The result is held
// in an output register; input is taken again the cycle after it leaves.
// ----------------------------------------------------------------------------
module drowsiness_window_indicators_top import dwi_pkg::*; #(
  parameter int unsigned RING_DEPTH  = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dwi_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dwi_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = TimeBits + 1;
  localparam int unsigned HW = HeightBits + 1;
  localparam logic [TimeBits-1:0] TMax = '1;
  // ceil(2^30 / 1000), exact floor for products below about 6e6
  localparam logic [20:0] MsRecip = 21'd1073742;

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_PPOP_RD, S_PPOP_CHK, S_PPUSH, S_DIV_GO, S_BPOP_RD,
    S_BPOP_CHK, S_BPUSH, S_SCAN, S_SCAN_WAIT, S_FIN, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [HeightBits-1:0] base_q;
  logic [7:0]            pth_q, cth_q;
  logic [TimeBits-1:0]   pwin_q, bwin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pth_q  <= '0;
      cth_q  <= '0;
      pwin_q <= TimeBits'(60000);
      bwin_q <= TimeBits'(60000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASELINE:    base_q <= cfg_data_i[HeightBits-1:0];
        REG_PERCLOS_TH:  pth_q  <= cfg_data_i[7:0];
        REG_CLOSURE_TH:  cth_q  <= cfg_data_i[7:0];
        REG_PERCLOS_WIN: pwin_q <= cfg_data_i[TimeBits-1:0];
        REG_BLINK_WIN:   bwin_q <= cfg_data_i[TimeBits-1:0];
        default: ;
      endcase
    end
  end

  // Frame state
  logic [HW-1:0]        last_h_q, h_q;
  logic [TimeBits-1:0]  timer_q;
  logic [IvBits-1:0]    iv_q;
  logic                 pcl_q, ccl_q;
  logic [AW-1:0]        phead_q, bhead_q;
  logic [CW-1:0]        pcnt_q, bcnt_q, scan_q;
  logic [SW-1:0]        pspan_q, pclosed_q, bspan_q;
  logic [11:0]          blinks_q;
  logic                 run_q;
  dwi_out_t             out_q;

  // Height selection
  logic [HeightBits-1:0] ha, hb, hmin;
  logic [HW-1:0]         hsel;
  assign ha   = in_data_i.eye_height_a;
  assign hb   = in_data_i.eye_height_b;
  assign hmin = (in_data_i.eyes_found >= 2'd2 && hb < ha) ? hb : ha;
  always_comb begin
    if (in_data_i.eyes_found == 2'd0) begin
      hsel = last_h_q;
    end else if ({1'b0, hmin} > {base_q, 1'b0}) begin
      hsel = {base_q, 1'b0};
    end else begin
      hsel = {1'b0, hmin};
    end
  end

  // Closed tests, evaluated in S_CALC
  logic [HW+7:0] hs;
  logic [HeightBits+7:0] pprod, cprod;
  logic                  pcl_now, ccl_now;
  assign hs      = {h_q, 8'd0};
  assign pprod   = base_q * pth_q;
  assign cprod   = base_q * cth_q;
  assign pcl_now = {1'b0, hs} < {1'b0, 1'b0, pprod};
  assign ccl_now = {1'b0, hs} < {1'b0, 1'b0, cprod};

  // Ring ports
  logic          p_we, b_we;
  logic [AW-1:0] p_wa, b_wa, p_ra, b_ra;
  logic [IvBits:0] p_rd, b_rd;

  dwi_ring #(.Depth(RING_DEPTH), .AW(AW)) u_pring (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i({pcl_q, iv_q}),
    .raddr_i(p_ra), .rdata_o(p_rd)
  );
  dwi_ring #(.Depth(RING_DEPTH), .AW(AW)) u_bring (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i({ccl_q, iv_q}),
    .raddr_i(b_ra), .rdata_o(b_rd)
  );

  logic [CW-1:0] psum, bsum, bidx;
  assign psum = {1'b0, phead_q} + pcnt_q;
  assign bsum = {1'b0, bhead_q} + bcnt_q;
  assign bidx = {1'b0, bhead_q} + scan_q;
  assign p_we = (state_q == S_PPUSH);
  assign b_we = (state_q == S_BPUSH);
  assign p_wa = psum[AW-1:0];
  assign b_wa = bsum[AW-1:0];
  assign p_ra = phead_q;
  assign b_ra = (state_q == S_SCAN) ? bidx[AW-1:0] : bhead_q;

  logic pop_p, pop_b;
  assign pop_p = (pcnt_q != '0) &&
                 (pspan_q > {1'b0, pwin_q} || pcnt_q == CW'(RING_DEPTH));
  assign pop_b = (bcnt_q != '0) &&
                 (bspan_q > {1'b0, bwin_q} || bcnt_q == CW'(RING_DEPTH));

  // Divider
  logic        div_go, div_busy;
  logic [12:0] div_q;
  assign div_go = (state_q == S_DIV_GO);
  dwi_div #(.NumBits(SW)) u_div (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(pclosed_q), .den_i(pspan_q),
    .busy_o(div_busy), .quot_o(div_q)
  );

  // Microsleep score: (t * k) / 1000 by reciprocal multiplication
  logic [TimeBits+11:0] ms_prod;
  logic [12:0]          ms_off;
  logic                 ms_sub;
  logic [12:0]          ms_val;
  always_comb begin
    ms_off = 13'd0;
    ms_sub = 1'b0;
    if (timer_q < TimeBits'(500)) begin
      ms_prod = (TimeBits+12)'(timer_q) << 10;
    end else if (timer_q < TimeBits'(1000)) begin
      ms_prod = (TimeBits+12)'(timer_q) << 11;
      ms_off  = 13'd512;
      ms_sub  = 1'b1;
    end else if (timer_q < TimeBits'(2000)) begin
      ms_prod = (TimeBits+12)'(timer_q) << 10;
      ms_off  = 13'd512;
    end else begin
      ms_prod = (TimeBits+12)'(timer_q) << 9;
      ms_off  = 13'd1536;
    end
  end
  logic [TimeBits+11:0] ms_prod_q;
  logic [12:0]          ms_off_q;
  logic                 ms_sub_q, ms_sat_q;
  logic [TimeBits+32:0] ms_mul;
  logic [12:0]          ms_quo;
  assign ms_mul = (TimeBits+33)'(ms_prod_q) * (TimeBits+33)'(MsRecip);
  assign ms_quo = ms_mul[30 +: 13];
  always_comb begin
    if (ms_sat_q) ms_val = 13'd4096;
    else if (ms_sub_q) ms_val = ms_quo - ms_off_q;
    else ms_val = ms_quo + ms_off_q;
  end

  logic [TimeBits:0] tsum;
  assign tsum = {1'b0, timer_q} + (TimeBits+1)'(iv_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = out_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      last_h_q  <= '0;
      timer_q   <= '0;
      phead_q   <= '0;
      bhead_q   <= '0;
      pcnt_q    <= '0;
      bcnt_q    <= '0;
      pspan_q   <= '0;
      pclosed_q <= '0;
      bspan_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          h_q      <= hsel;
          last_h_q <= hsel;
          iv_q     <= in_data_i.interval_ms;
          state_q  <= S_CALC;
        end
        S_CALC: begin
          pcl_q <= pcl_now;
          ccl_q <= ccl_now;
          pspan_q <= pspan_q + SW'(iv_q);
          if (pcl_now) pclosed_q <= pclosed_q + SW'(iv_q);
          bspan_q <= bspan_q + SW'(iv_q);
          state_q <= S_PPOP_RD;
        end
        S_PPOP_RD: begin
          // pops read at phead; data next cycle
          state_q <= pop_p ? S_PPOP_CHK : S_PPUSH;
        end
        S_PPOP_CHK: begin
          pspan_q <= pspan_q - SW'(p_rd[IvBits-1:0]);
          if (p_rd[IvBits]) pclosed_q <= pclosed_q - SW'(p_rd[IvBits-1:0]);
          phead_q <= phead_q + 1'b1;
          pcnt_q  <= pcnt_q - 1'b1;
          state_q <= S_PPOP_RD;
        end
        S_PPUSH: begin
          pcnt_q  <= pcnt_q + 1'b1;
          if (ccl_q) timer_q <= tsum[TimeBits] ? TMax : tsum[TimeBits-1:0];
          else timer_q <= (timer_q > TimeBits'(iv_q)) ?
                          timer_q - TimeBits'(iv_q) : '0;
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: state_q <= pop_b ? S_BPOP_CHK : S_BPUSH;
        S_BPOP_RD: state_q <= pop_b ? S_BPOP_CHK : S_BPUSH;
        S_BPOP_CHK: begin
          bspan_q <= bspan_q - SW'(b_rd[IvBits-1:0]);
          bhead_q <= bhead_q + 1'b1;
          bcnt_q  <= bcnt_q - 1'b1;
          state_q <= S_BPOP_RD;
        end
        S_BPUSH: begin
          bcnt_q   <= bcnt_q + 1'b1;
          scan_q   <= '0;
          blinks_q <= '0;
          run_q    <= 1'b0;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          scan_q  <= scan_q + 1'b1;
          state_q <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: begin
          if (b_rd[IvBits] && !run_q) blinks_q <= blinks_q + 1'b1;
          run_q <= b_rd[IvBits];
          state_q <= (scan_q == bcnt_q) ? S_FIN : S_SCAN;
        end
        S_FIN: if (!div_busy) begin
          out_q.eye_height      <= h_q;
          out_q.perclos_q12     <= (pspan_q != '0 &&
                                    {pspan_q, 1'b0} >= (SW+1)'(pwin_q)) ? div_q : '0;
          out_q.closure_time_ms <= timer_q;
          out_q.microsleep_q12  <= ms_val;
          out_q.blink_count     <= blinks_q;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Microsleep operand register
  always_ff @(posedge clk_i) begin
    ms_prod_q <= ms_prod;
    ms_off_q  <= ms_off;
    ms_sub_q  <= ms_sub;
    ms_sat_q  <= (timer_q >= TimeBits'(5000));
  end

endmodule

FILE: rtl/core/dwi_div.sv
// ----------------------------------------------------------------------------
// dwi_div
// Restoring divider, one quotient bit per cycle: (num * 4096) / den.
// ----------------------------------------------------------------------------
module dwi_div import dwi_pkg::*; #(
  parameter int unsigned NumBits = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [NumBits-1:0] den_i,
  output logic               busy_o,
  output logic [12:0]        quot_o
);

  localparam int unsigned QBits = NumBits + 13;
  localparam int unsigned CntBits = $clog2(QBits + 1);

  logic [QBits-1:0]   dvd_q;
  logic [NumBits:0]   rem_q;
  logic [NumBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q;
  logic [NumBits+1:0] trial;

  assign trial  = {rem_q, dvd_q[QBits-1]} - {2'b0, den_q};
  assign busy_o = (cnt_q != '0);
  assign quot_o = dvd_q[12:0];

  // Shift and subtract
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntBits'(QBits);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, 13'd0} >> 1;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      if (!trial[NumBits+1]) begin
        rem_q <= trial[NumBits:0];
        dvd_q <= {dvd_q[QBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NumBits-1:0], dvd_q[QBits-1]};
        dvd_q <= {dvd_q[QBits-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/core/dwi_ring.sv
// ----------------------------------------------------------------------------
// dwi_ring
// Ring memory of per-frame entries {closed, interval}, one read port with a
// registered output and one write port.
// ----------------------------------------------------------------------------
module dwi_ring import dwi_pkg::*; #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [IvBits:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [IvBits:0] rdata_o
);

  logic [IvBits:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Frame-level check of the drowsiness window indicators. A directed table and
// then random frame sequences (closure runs, saturating closures, long windows
// with short intervals) are sent under several register settings. Every
// result is compared with its typed table result or with a predictor that
// keeps its own copy of both time windows and the closure timer.
// ----------------------------------------------------------------------------
module tb_top;
  import dwi_pkg::*;

  localparam int unsigned RingDepth  = 2048;
  localparam int unsigned TimeMax    = 65535;
  localparam int unsigned Settle     = 3000;
  localparam longint     CycleLimit = 40_000_000;
  localparam logic [2:0] RegSpareLo = 3'd5;
  localparam logic [2:0] RegSpareHi = 3'd7;

  typedef struct {
    logic [9:0] iv;
    bit         shut;
  } slot_t;

  typedef struct {
    dwi_in_t  frame;
    bit       typed;
    dwi_out_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  dwi_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  dwi_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // predictor state and register copy
  int unsigned base_h, perclos_th, closure_th, perclos_win, blink_win;
  int unsigned last_h, shut_timer;
  slot_t       perclos_q[$];
  slot_t       blink_q[$];
  int unsigned perclos_span, perclos_shut, blink_span, blink_dummy;

  dwi_out_t    pending_res[$];
  int unsigned mismatches = 0;
  bit          idle_en = 1'b1;
  bit          eye_shut = 1'b0;
  int unsigned flip_pct = 15;
  longint      cycles = 0;
  row_t        rows[$];

  drowsiness_window_indicators_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // time window: add, pop oldest while over span, drop oldest if full, push
  function automatic void slide(ref slot_t q[$], ref int unsigned span,
                                ref int unsigned shut_t, input int unsigned win,
                                input int unsigned iv, input bit shut);
    slot_t s;
    span += iv;
    if (shut) shut_t += iv;
    while (span > win && q.size() > 0) begin
      s = q[0];
      q.delete(0);
      span -= s.iv;
      if (s.shut) shut_t -= s.iv;
    end
    if (q.size() >= RingDepth) begin
      s = q[0];
      q.delete(0);
      span -= s.iv;
      if (s.shut) shut_t -= s.iv;
    end
    s.iv = iv[9:0];
    s.shut = shut;
    q.insert(q.size(), s);
  endfunction

  function automatic dwi_out_t predict_frame(dwi_in_t f);
    dwi_out_t    r;
    int unsigned h, iv, pq, runs, t, sc;
    bit          p_shut, c_shut, run;
    iv = f.interval_ms;
    if (f.eyes_found == 2'd0) begin
      h = last_h;
    end else begin
      h = f.eye_height_a;
      if (f.eyes_found >= 2'd2 && f.eye_height_b < h) h = f.eye_height_b;
      if (h > 2 * base_h) h = 2 * base_h;
    end
    h &= 32'h7ff;
    last_h = h;
    p_shut = (h * 256) < (base_h * perclos_th);
    c_shut = (h * 256) < (base_h * closure_th);

    slide(perclos_q, perclos_span, perclos_shut, perclos_win, iv, p_shut);
    pq = 0;
    if (perclos_span != 0 && 2 * perclos_span >= perclos_win)
      pq = (perclos_shut * 4096) / perclos_span;

    if (c_shut) begin
      shut_timer += iv;
      if (shut_timer > TimeMax) shut_timer = TimeMax;
    end else begin
      shut_timer = (shut_timer > iv) ? shut_timer - iv : 0;
    end

    blink_dummy = 0;
    slide(blink_q, blink_span, blink_dummy, blink_win, iv, c_shut);
    runs = 0;
    run = 1'b0;
    foreach (blink_q[k]) begin
      if (blink_q[k].shut && !run) runs++;
      run = blink_q[k].shut;
    end

    // piecewise microsleep score
    t = shut_timer;
    if (t < 500) sc = (t * 1024) / 1000;
    else if (t < 1000) sc = (t * 2048) / 1000 - 512;
    else if (t < 2000) sc = (t * 1024) / 1000 + 512;
    else if (t < 5000) sc = (t * 512) / 1000 + 1536;
    else sc = 4096;

    r.eye_height = h[10:0];
    r.perclos_q12 = pq[12:0];
    r.closure_time_ms = shut_timer[15:0];
    r.microsleep_q12 = sc[12:0];
    r.blink_count = runs[11:0];
    return r;
  endfunction

  function automatic dwi_in_t mk(int unsigned n, int unsigned a, int unsigned b,
                                 int unsigned iv);
    dwi_in_t f;
    f.eyes_found = n[1:0];
    f.eye_height_a = a[9:0];
    f.eye_height_b = b[9:0];
    f.interval_ms = iv[9:0];
    return f;
  endfunction

  function automatic dwi_out_t lit(int unsigned h);
    dwi_out_t r;
    r = '0;
    r.eye_height = h[10:0];
    return r;
  endfunction

  // one row of the directed table
  function automatic void add_row(dwi_in_t f, bit typed, dwi_out_t res);
    row_t r;
    r.frame = f;
    r.typed = typed;
    r.res = res;
    rows.insert(rows.size(), r);
  endfunction

  // random frame: closure runs of random length, some raw noise
  function automatic dwi_in_t rand_frame(int unsigned iv_max);
    dwi_in_t     f;
    int unsigned sel, hi, lo;
    if ($urandom_range(0, 99) < flip_pct) eye_shut = ~eye_shut;
    sel = $urandom_range(0, 99);
    f.eyes_found = (sel < 8) ? 2'd0 : (sel < 14) ? 2'd3 : (sel < 35) ? 2'd1 : 2'd2;
    if ($urandom_range(0, 99) < 15) begin
      f.eye_height_a = 10'($urandom);
      f.eye_height_b = 10'($urandom);
    end else if (eye_shut) begin
      hi = (base_h * closure_th) >> 8;
      f.eye_height_a = 10'($urandom_range(0, hi));
      f.eye_height_b = 10'($urandom_range(0, hi));
    end else begin
      lo = (base_h > 1023) ? 1023 : base_h;
      hi = (2 * base_h > 1023) ? 1023 : 2 * base_h;
      f.eye_height_a = 10'($urandom_range(lo, hi));
      f.eye_height_b = 10'($urandom_range(lo, hi));
    end
    if ($urandom_range(0, 9) == 0) f.interval_ms = 10'($urandom_range(1, 1000));
    else f.interval_ms = 10'($urandom_range(1, iv_max));
    return f;
  endfunction

  // send one frame request; on acceptance predict or take the typed result
  task automatic send_frame(dwi_in_t f, bit typed, dwi_out_t res);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 15) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (typed) begin
      void'(predict_frame(f));
      pending_res.insert(pending_res.size(), res);
    end else begin
      pending_res.insert(pending_res.size(), predict_frame(f));
    end
  endtask

  // hold off new requests until every result is back and the block settles
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    logic [31:0] mask, d;
    case (reg_idx_e'(idx))
      REG_BASELINE:   mask = 32'h3ff;
      REG_PERCLOS_TH: mask = 32'hff;
      REG_CLOSURE_TH: mask = 32'hff;
      REG_PERCLOS_WIN, REG_BLINK_WIN: mask = 32'hffff;
      default:        mask = 32'h0;
    endcase
    // junk above the register width must be ignored
    d = (val & mask) | ($urandom & ~mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (reg_idx_e'(idx))
      REG_BASELINE:    base_h = d & mask;
      REG_PERCLOS_TH:  perclos_th = d & mask;
      REG_CLOSURE_TH:  closure_th = d & mask;
      REG_PERCLOS_WIN: perclos_win = d & mask;
      REG_BLINK_WIN:   blink_win = d & mask;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(int unsigned b, int unsigned pt, int unsigned ct,
                          int unsigned pw, int unsigned bw);
    write_reg(REG_BASELINE, b);
    write_reg(REG_PERCLOS_TH, pt);
    write_reg(REG_CLOSURE_TH, ct);
    write_reg(REG_PERCLOS_WIN, pw);
    write_reg(REG_BLINK_WIN, bw);
    @(posedge clk_i);
  endtask

  task automatic rand_burst(int unsigned n, int unsigned iv_max);
    repeat (n) send_frame(rand_frame(iv_max), 1'b0, '0);
  endtask

  // result side: random stall, compare with the oldest expectation
  initial begin : result_check
    int unsigned hold;
    dwi_out_t    want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data_o);
        end else begin
          want = pending_res[0];
          pending_res.delete(0);
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp h=%0d pc=%0d t=%0d ms=%0d bl=%0d",
                       want.eye_height, want.perclos_q12, want.closure_time_ms,
                       want.microsleep_q12, want.blink_count);
              $display("          got h=%0d pc=%0d t=%0d ms=%0d bl=%0d",
                       out_data_o.eye_height, out_data_o.perclos_q12,
                       out_data_o.closure_time_ms, out_data_o.microsleep_q12,
                       out_data_o.blink_count);
            end
          end
        end
        hold = idle_en ? $urandom_range(0, 15) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    base_h = 0;
    perclos_th = 0;
    closure_th = 0;
    perclos_win = 60000;
    blink_win = 60000;
    last_h = 0;
    shut_timer = 0;
    perclos_span = 0;
    perclos_shut = 0;
    blink_span = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the baseline is zero: every height clips to zero, nothing closes
    add_row(mk(2, 1023, 1023, 1000), 1'b1, lit(0));
    add_row(mk(0, 0, 0, 1), 1'b1, lit(0));
    add_row(mk(3, 512, 1, 1), 1'b1, lit(0));
    add_row(mk(1, 1023, 0, 1000), 1'b1, lit(0));
    foreach (rows[i]) send_frame(rows[i].frame, rows[i].typed, rows[i].res);
    drain();

    // full baseline, unknown indexes ignored
    set_regs(1023, 128, 192, 1500, 4000);
    for (int i = RegSpareLo; i <= RegSpareHi; i++) write_reg(i[2:0], 32'hffff_ffff);
    rows.delete();
    add_row(mk(2, 1023, 1023, 1), 1'b1, lit(1023));
    add_row(mk(1, 0, 1023, 1000), 1'b0, '0);
    add_row(mk(0, 1023, 1023, 1000), 1'b0, '0);
    add_row(mk(3, 1023, 0, 1000), 1'b0, '0);
    add_row(mk(2, 0, 700, 1000), 1'b0, '0);
    add_row(mk(1, 1023, 0, 1), 1'b0, '0);
    add_row(mk(2, 300, 800, 999), 1'b0, '0);
    add_row(mk(2, 767, 766, 500), 1'b0, '0);
    add_row(mk(0, 5, 5, 250), 1'b0, '0);
    add_row(mk(1, 1023, 1023, 1000), 1'b0, '0);
    add_row(mk(2, 1, 0, 1), 1'b0, '0);
    add_row(mk(3, 5, 1020, 250), 1'b0, '0);
    add_row(mk(1, 600, 0, 600), 1'b0, '0);
    add_row(mk(2, 512, 511, 1000), 1'b0, '0);
    foreach (rows[i]) send_frame(rows[i].frame, rows[i].typed, rows[i].res);
    drain();

    // extremes: widest windows and thresholds
    set_regs(1023, 255, 255, 65535, 65535);
    flip_pct = 5;
    rand_burst(100, 100);
    drain();

    // smallest windows, zero baseline and thresholds
    set_regs(0, 0, 0, 1, 1);
    rand_burst(60, 1000);
    drain();

    // no idling on either side
    idle_en = 1'b0;
    set_regs(200, 77, 51, 2000, 5000);
    flip_pct = 20;
    rand_burst(100, 200);
    drain();
    idle_en = 1'b1;

    // long closures drive the timer into saturation, then recovery
    set_regs(1023, 200, 255, 30000, 20000);
    repeat (80) send_frame(mk($urandom_range(1, 3), $urandom_range(0, 900),
                              $urandom_range(0, 900), $urandom_range(900, 1000)),
                           1'b0, '0);
    repeat (30) send_frame(mk(2, 1023, 1023, $urandom_range(1, 1000)), 1'b0, '0);
    drain();

    // random settings
    repeat (4) begin
      set_regs($urandom_range(1, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(1, 65535), $urandom_range(1, 20000));
      flip_pct = $urandom_range(5, 30);
      rand_burst(60, 150);
      drain();
    end

    // long windows with short intervals keep many entries in both rings
    idle_en = 1'b0;
    set_regs(1023, 255, 128, 65535, 65535);
    flip_pct = 25;
    rand_burst(100, 3);
    drain();

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/dwi_pkg.sv
rtl/core/dwi_div.sv
rtl/core/dwi_ring.sv
rtl/core/drowsiness_window_indicators_top.sv
sim/tb_top.sv
